// ===== sv/gbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbfs_pkg: shared types and constants for the grid path finder
// Cell codes, commands, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package gbfs_pkg;

  localparam int MaxRowsDef = 64;
  localparam int MaxColsDef = 64;
  localparam int LenMax     = 4095;

  localparam logic [2:0] T_EMPTY    = 3'd0;
  localparam logic [2:0] T_WALL     = 3'd1;
  localparam logic [2:0] T_END      = 3'd2;
  localparam logic [2:0] T_EXPLORED = 3'd3;
  localparam logic [2:0] T_PATH     = 3'd4;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNDEF  = 2'd3;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_SROW = 2'd2;
  localparam logic [1:0] REG_SCOL = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD_RD,
    ST_CLEAR,
    ST_POP,
    ST_POP_WAIT,
    ST_NB,
    ST_NB_WAIT,
    ST_NB_EVAL,
    ST_TRACE,
    ST_TRACE_WAIT,
    ST_DONE
  } state_t;

endpackage

// ===== sv/grid_bfs_path_finder.sv =====
// Search: clears every visited entry (MAX_ROWS times MAX_COLS, each rounded up to a power
//   of two), then pops queued cells, checks each neighbour and traces the path cells.
// Throughput: one command at a time; search speed is set by one-port access to the cell,
//   visited and parent memories.
// Reset (rst_n, synchronous): registers back to 64x64 grid, start 0,0; found and length zero.
// ----------------------------------------------------------------------------
// grid_bfs_path_finder: breadth-first grid path search
// Memory-based sequencer over cell, visited, parent and queue stores.
// ----------------------------------------------------------------------------
module grid_bfs_path_finder #(
  parameter int MAX_ROWS = gbfs_pkg::MaxRowsDef,
  parameter int MAX_COLS = gbfs_pkg::MaxColsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cmd[1:0], row[7:2], col[13:8], write_type[16:14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_type[2:0], found[3], path_length[15:4]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = RW + CW;
  localparam int NCELL = 1 << AW;
  localparam int QW = AW + 1;

  // config
  logic [6:0] rows_r, cols_r;
  logic [5:0] srow_r, scol_r;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 7'd64; cols_r <= 7'd64; srow_r <= '0; scol_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        gbfs_pkg::REG_ROWS: rows_r <= cfg_pwdata[6:0];
        gbfs_pkg::REG_COLS: cols_r <= cfg_pwdata[6:0];
        gbfs_pkg::REG_SROW: srow_r <= cfg_pwdata[5:0];
        gbfs_pkg::REG_SCOL: scol_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[3:2])
      gbfs_pkg::REG_ROWS: cfg_prdata = {25'd0, rows_r};
      gbfs_pkg::REG_COLS: cfg_prdata = {25'd0, cols_r};
      gbfs_pkg::REG_SROW: cfg_prdata = {26'd0, srow_r};
      gbfs_pkg::REG_SCOL: cfg_prdata = {26'd0, scol_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // clamped bounds
  logic [10:0] nrows, ncols;
  always_comb begin
    nrows = (rows_r == 7'd0) ? 11'd1 :
            ({4'd0, rows_r} > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : {4'd0, rows_r};
    ncols = (cols_r == 7'd0) ? 11'd1 :
            ({4'd0, cols_r} > 11'(MAX_COLS)) ? 11'(MAX_COLS) : {4'd0, cols_r};
  end

  // memories
  logic [2:0]    cell_mem [NCELL];
  logic          vis_mem  [NCELL];
  logic [1:0]    par_mem  [NCELL];
  logic [AW-1:0] q_mem    [NCELL];

  logic          cell_we, vis_we, par_we, q_we;
  logic [AW-1:0] cell_a, vis_a, par_a, q_wa, q_ra;
  logic [2:0]    cell_wd, cell_rd;
  logic          vis_wd, vis_rd;
  logic [1:0]    par_wd, par_rd;
  logic [AW-1:0] q_wd, q_rd;

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_a] <= cell_wd;
    cell_rd <= cell_mem[cell_a];
  end
  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_a] <= vis_wd;
    vis_rd <= vis_mem[vis_a];
  end
  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_a] <= par_wd;
    par_rd <= par_mem[par_a];
  end
  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd <= q_mem[q_ra];
  end

  // sequencer
  gbfs_pkg::state_t st_r, st_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [2:0]    wt_r, wt_nxt;
  logic [QW-1:0] clr_r, clr_nxt;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [RW-1:0] hr_r, hr_nxt;
  logic [CW-1:0] hc_r, hc_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic [RW-1:0] nr_r, nr_nxt;
  logic [CW-1:0] nc_r, nc_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic          found_r, found_nxt;
  logic [11:0]   len_r, len_nxt;
  logic [QW-1:0] guard_r, guard_nxt;
  logic [2:0]    rt_r, rt_nxt;
  logic          ov_r, ov_nxt;

  logic [5:0]    in_row, in_col;
  logic [AW-1:0] in_idx, st_idx;
  logic          in_inside, in_fire, out_fire;
  logic [11:0]   tr, tc;   // neighbour candidate, signed-safe wide
  logic          nb_ok;
  logic [11:0]   pr, pc;

  assign in_row   = in_tdata[7:2];
  assign in_col   = in_tdata[13:8];
  assign in_idx   = {RW'(in_row), CW'(in_col)};
  assign st_idx   = {RW'(srow_r), CW'(scol_r)};
  assign in_inside = ({1'b0, in_row} < 7'(MAX_ROWS > 64 ? 64 : MAX_ROWS)) &&
                     ({1'b0, in_col} < 7'(MAX_COLS > 64 ? 64 : MAX_COLS));
  assign in_tready = (st_r == gbfs_pkg::ST_IDLE) && !ov_r;
  assign in_fire   = in_tvalid & in_tready;
  assign out_tvalid = ov_r;
  assign out_fire  = ov_r & out_tready;
  assign out_tdata = {len_r, found_r, rt_r};

  always_comb begin
    tr = {{(12-RW){1'b0}}, hr_r};
    tc = {{(12-CW){1'b0}}, hc_r};
    case (dir_r)
      gbfs_pkg::DIR_UP:    tr = tr - 12'd1;
      gbfs_pkg::DIR_RIGHT: tc = tc + 12'd1;
      gbfs_pkg::DIR_DOWN:  tr = tr + 12'd1;
      default:             tc = tc - 12'd1;
    endcase
    nb_ok = !tr[11] && !tc[11] && (tr < {1'b0, nrows}) && (tc < {1'b0, ncols});
    pr = {{(12-RW){1'b0}}, nr_r};
    pc = {{(12-CW){1'b0}}, nc_r};
    case (par_rd)
      gbfs_pkg::DIR_UP:    pr = pr + 12'd1;
      gbfs_pkg::DIR_RIGHT: pc = pc - 12'd1;
      gbfs_pkg::DIR_DOWN:  pr = pr - 12'd1;
      default:             pc = pc + 12'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= gbfs_pkg::ST_IDLE; ov_r <= 1'b0; found_r <= 1'b0; len_r <= '0;
      head_r <= '0; tail_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; found_r <= found_nxt; len_r <= len_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt;
    end
    idx_r <= idx_nxt; wt_r <= wt_nxt;
    clr_r <= clr_nxt; hr_r <= hr_nxt; hc_r <= hc_nxt; dir_r <= dir_nxt;
    nr_r <= nr_nxt; nc_r <= nc_nxt; start_r <= start_nxt; guard_r <= guard_nxt;
    rt_r <= rt_nxt;
  end

  always_comb begin
    st_nxt = st_r; ov_nxt = ov_r; found_nxt = found_r; len_nxt = len_r;
    head_nxt = head_r; tail_nxt = tail_r;
    idx_nxt = idx_r; wt_nxt = wt_r; clr_nxt = clr_r; hr_nxt = hr_r; hc_nxt = hc_r;
    dir_nxt = dir_r; nr_nxt = nr_r; nc_nxt = nc_r; start_nxt = start_r;
    guard_nxt = guard_r; rt_nxt = rt_r;
    cell_we = 1'b0; cell_a = idx_r; cell_wd = wt_r;
    vis_we = 1'b0; vis_a = {nr_r, nc_r}; vis_wd = 1'b0;
    par_we = 1'b0; par_a = {nr_r, nc_r}; par_wd = dir_r;
    q_we = 1'b0; q_wa = tail_r[AW-1:0]; q_wd = {nr_r, nc_r}; q_ra = head_r[AW-1:0];
    if (out_fire) ov_nxt = 1'b0;
    case (st_r)
      gbfs_pkg::ST_IDLE: begin
        if (in_fire) begin
          idx_nxt = in_idx;
          wt_nxt = in_tdata[16:14];
          rt_nxt = '0;
          st_nxt = gbfs_pkg::ST_DONE;
          if (in_tdata[1:0] == gbfs_pkg::CMD_WRITE && in_inside) begin
            cell_we = 1'b1; cell_a = in_idx;
            cell_wd = in_tdata[16:14];
          end else if (in_tdata[1:0] == gbfs_pkg::CMD_READ && in_inside) begin
            cell_a = in_idx;
            st_nxt = gbfs_pkg::ST_CMD_RD;
          end else if (in_tdata[1:0] == gbfs_pkg::CMD_SEARCH) begin
            found_nxt = 1'b0; len_nxt = '0; clr_nxt = '0;
            head_nxt = '0; tail_nxt = '0;
            st_nxt = gbfs_pkg::ST_CLEAR;
          end
        end
      end
      gbfs_pkg::ST_CMD_RD: begin
        rt_nxt = cell_rd;
        st_nxt = gbfs_pkg::ST_DONE;
      end
      gbfs_pkg::ST_CLEAR: begin
        vis_we = 1'b1; vis_a = clr_r[AW-1:0]; vis_wd = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == QW'(NCELL - 1)) begin
          if ({5'd0, srow_r} >= nrows || {5'd0, scol_r} >= ncols) begin
            st_nxt = gbfs_pkg::ST_DONE;
          end else begin
            st_nxt = gbfs_pkg::ST_POP;
          end
        end
        if (clr_r == QW'(NCELL)) begin
          // seed the start cell
          vis_a = st_idx; vis_wd = 1'b1;
          q_we = 1'b1; q_wa = '0; q_wd = st_idx;
          start_nxt = st_idx;
          tail_nxt = QW'(1);
          st_nxt = gbfs_pkg::ST_POP;
        end else if (clr_r == QW'(NCELL - 1)) begin
          st_nxt = st_nxt == gbfs_pkg::ST_DONE ? gbfs_pkg::ST_DONE : gbfs_pkg::ST_CLEAR;
        end
      end
      gbfs_pkg::ST_POP: begin
        if (head_r < tail_r) begin
          q_ra = head_r[AW-1:0];
          head_nxt = head_r + 1'b1;
          st_nxt = gbfs_pkg::ST_POP_WAIT;
        end else begin
          st_nxt = gbfs_pkg::ST_DONE;
        end
      end
      gbfs_pkg::ST_POP_WAIT: begin
        hr_nxt = q_rd[AW-1:CW]; hc_nxt = q_rd[CW-1:0];
        dir_nxt = gbfs_pkg::DIR_UP;
        st_nxt = gbfs_pkg::ST_NB;
      end
      gbfs_pkg::ST_NB: begin
        if (nb_ok) begin
          nr_nxt = tr[RW-1:0]; nc_nxt = tc[CW-1:0];
          vis_a = {tr[RW-1:0], tc[CW-1:0]};
          cell_a = {tr[RW-1:0], tc[CW-1:0]};
          st_nxt = gbfs_pkg::ST_NB_WAIT;
        end else if (dir_r == gbfs_pkg::DIR_LEFT) begin
          st_nxt = gbfs_pkg::ST_POP;
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end
      gbfs_pkg::ST_NB_WAIT: begin
        cell_a = {nr_r, nc_r};
        st_nxt = gbfs_pkg::ST_NB_EVAL;
      end
      gbfs_pkg::ST_NB_EVAL: begin
        cell_a = {nr_r, nc_r};
        st_nxt = (dir_r == gbfs_pkg::DIR_LEFT) ? gbfs_pkg::ST_POP : gbfs_pkg::ST_NB;
        dir_nxt = dir_r + 2'd1;
        if (!vis_rd && cell_rd != gbfs_pkg::T_WALL) begin
          par_we = 1'b1;
          if (cell_rd == gbfs_pkg::T_END) begin
            found_nxt = 1'b1; len_nxt = '0; guard_nxt = '0;
            st_nxt = gbfs_pkg::ST_TRACE;
          end else begin
            vis_we = 1'b1; vis_wd = 1'b1;
            cell_we = 1'b1; cell_wd = gbfs_pkg::T_EXPLORED;
            if (tail_r < QW'(NCELL)) begin
              q_we = 1'b1;
              tail_nxt = tail_r + 1'b1;
            end
          end
        end
      end
      gbfs_pkg::ST_TRACE: begin
        if ({nr_r, nc_r} == start_r || guard_r >= QW'(NCELL)) begin
          st_nxt = gbfs_pkg::ST_DONE;
        end else begin
          st_nxt = gbfs_pkg::ST_TRACE_WAIT;
        end
      end
      gbfs_pkg::ST_TRACE_WAIT: begin
        if (cell_rd != gbfs_pkg::T_END) begin
          cell_we = 1'b1; cell_wd = gbfs_pkg::T_PATH;
        end
        cell_a = {nr_r, nc_r};
        if (len_r != 12'(gbfs_pkg::LenMax)) len_nxt = len_r + 12'd1;
        guard_nxt = guard_r + 1'b1;
        if (pr[11] || pc[11] || pr >= 12'(MAX_ROWS) || pc >= 12'(MAX_COLS)) begin
          st_nxt = gbfs_pkg::ST_DONE;
        end else begin
          nr_nxt = pr[RW-1:0]; nc_nxt = pc[CW-1:0];
          st_nxt = gbfs_pkg::ST_TRACE;
        end
      end
      gbfs_pkg::ST_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          st_nxt = gbfs_pkg::ST_IDLE;
        end
      end
      default: st_nxt = gbfs_pkg::ST_IDLE;
    endcase
    // trace: the entry's reads must be issued the cycle we enter ST_TRACE
    if (st_r == gbfs_pkg::ST_NB_EVAL && st_nxt == gbfs_pkg::ST_TRACE) begin
      cell_a = {nr_r, nc_r};
      par_a = {nr_r, nc_r};
    end
    if (st_r == gbfs_pkg::ST_TRACE) begin
      cell_a = {nr_r, nc_r};
      par_a = {nr_r, nc_r};
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != gbfs_pkg::ST_IDLE) |-> !in_tready) else $error("accept while busy");
  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= tail_r)) else $error("queue head past tail");
  a_len_found: assert property (@(posedge clk) disable iff (!rst_n)
    (!found_r |-> len_r == '0)) else $error("length without path");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> ov_r) else $error("result dropped");
`endif

endmodule

// ===== sim/tb_grid_bfs_path_finder.sv =====
// ----------------------------------------------------------------------------
// tb_grid_bfs_path_finder: self-checking bench for the grid path finder
// Drives cell writes, reads and searches over several grid bounds and start
// cells, predicts every result with a behavioral search of its own and checks
// each output transfer in order, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_grid_bfs_path_finder;

  localparam int NCOLS = 64;
  localparam int NCELL = 4096;
  localparam int CYCLE_LIMIT = 4000000;

  class grid_scoreboard;
    bit [2:0]  cells[NCELL];
    bit        seen[NCELL];
    bit [1:0]  came_from[NCELL];
    int        fifo[NCELL];
    bit [6:0]  rows_cfg = 7'd64, cols_cfg = 7'd64;
    bit [5:0]  srow_cfg, scol_cfg;
    bit        found_q;
    bit [11:0] len_q;
    bit [15:0] expected_q[$];
    int        errors;

    function int clamp(bit [6:0] v);
      if (v == 0) return 1;
      return (v > 64) ? 64 : v;
    endfunction

    function void set_reg(int idx, bit [6:0] v);
      case (idx)
        gbfs_pkg::REG_ROWS: rows_cfg = v;
        gbfs_pkg::REG_COLS: cols_cfg = v;
        gbfs_pkg::REG_SROW: srow_cfg = v[5:0];
        default:  scol_cfg = v[5:0];
      endcase
    endfunction

    function void search();
      int nr, nc, head, tail, start, goal, here, r, c, d, q, s, k, steps, cur;
      bit hit;
      nr = clamp(rows_cfg);
      nc = clamp(cols_cfg);
      found_q = 0;
      len_q = 0;
      foreach (seen[i]) seen[i] = 0;
      if (srow_cfg >= nr || scol_cfg >= nc) return;
      start = srow_cfg * NCOLS + scol_cfg;
      seen[start] = 1;
      fifo[0] = start;
      head = 0;
      tail = 1;
      hit = 0;
      while (!hit && head < tail) begin
        here = fifo[head++];
        r = here / NCOLS;
        c = here % NCOLS;
        for (d = 0; d < 4; d++) begin
          q = r + ((d == gbfs_pkg::DIR_UP) ? -1 : (d == gbfs_pkg::DIR_DOWN) ? 1 : 0);
          s = c + ((d == gbfs_pkg::DIR_LEFT) ? -1 : (d == gbfs_pkg::DIR_RIGHT) ? 1 : 0);
          if (q < 0 || s < 0 || q >= nr || s >= nc) continue;
          k = q * NCOLS + s;
          if (seen[k] || cells[k] == gbfs_pkg::T_WALL) continue;
          came_from[k] = 2'(d);
          if (cells[k] == gbfs_pkg::T_END) begin
            goal = k;
            hit = 1;
            break;
          end
          seen[k] = 1;
          cells[k] = gbfs_pkg::T_EXPLORED;
          if (tail < NCELL) fifo[tail++] = k;
        end
      end
      if (!hit) return;
      found_q = 1;
      steps = 0;
      cur = goal;
      for (int g = 0; cur != start && g < NCELL; g++) begin
        d = came_from[cur];
        r = cur / NCOLS - ((d == gbfs_pkg::DIR_UP) ? -1 : (d == gbfs_pkg::DIR_DOWN) ? 1 : 0);
        c = cur % NCOLS - ((d == gbfs_pkg::DIR_LEFT) ? -1 : (d == gbfs_pkg::DIR_RIGHT) ? 1 : 0);
        if (cells[cur] != gbfs_pkg::T_END) cells[cur] = gbfs_pkg::T_PATH;
        if (steps < gbfs_pkg::LenMax) steps++;
        if (r < 0 || c < 0 || r >= 64 || c >= 64) break;
        cur = r * NCOLS + c;
      end
      len_q = 12'(steps);
    endfunction

    function void note_input(bit [23:0] d);
      bit [2:0] rt;
      int idx;
      rt = 0;
      idx = d[7:2] * NCOLS + d[13:8];
      case (d[1:0])
        gbfs_pkg::CMD_WRITE:  cells[idx] = d[16:14];
        gbfs_pkg::CMD_SEARCH: search();
        gbfs_pkg::CMD_READ:   rt = cells[idx];
        default: ;
      endcase
      expected_q.insert(expected_q.size(), {len_q, found_q, rt});
    endfunction

    function void check_result(bit [15:0] got);
      bit [15:0] e;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer %h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (e[2:0] != got[2:0]) begin
        $error("read_type expected %0d actual %0d", e[2:0], got[2:0]);
        errors++;
      end
      if (e[3] != got[3]) begin
        $error("found expected %0d actual %0d", e[3], got[3]);
        errors++;
      end
      if (e[15:4] != got[15:4]) begin
        $error("path_length expected %0d actual %0d", e[15:4], got[15:4]);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [15:0] out_tdata;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  grid_bfs_path_finder dut (.*);

  grid_scoreboard sb = new();
  bit     written[NCELL];
  int     written_list[$];
  bit     quiet, hold_req;
  int     cycles = 0;
  bit [5:0] blk_r0, blk_c0, blk_r1, blk_c1;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: check, then pick next ready; one long hold-off on request
  initial begin
    int hold;
    bit hold_done;
    hold = 0;
    hold_done = 0;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (hold > 0) begin
        hold--;
        out_tready <= 0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1;
        hold = 400;
        out_tready <= 0;
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= 38);
      end
    end
  end

  task automatic send(bit [1:0] cmd, bit [5:0] r, bit [5:0] c, bit [2:0] wt);
    if (!quiet && $urandom_range(99) < 38) begin
      in_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 38);
    end
    in_tvalid <= 1;
    in_tdata  <= {7'd0, wt, c, r, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_input({7'd0, wt, c, r, cmd});
    if (cmd == gbfs_pkg::CMD_WRITE && !written[r * NCOLS + c]) begin
      written[r * NCOLS + c] = 1;
      written_list.insert(written_list.size(), r * NCOLS + c);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(bit [1:0] idx, bit [6:0] v);
    @(posedge clk);
    cfg_psel    <= 1;
    cfg_pwrite  <= 1;
    cfg_penable <= 0;
    cfg_paddr   <= 4'(idx) << 2;
    cfg_pwdata  <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic random_item(bit walled);
    int p, k;
    bit [5:0] r, c;
    bit [2:0] wt;
    p = $urandom_range(99);
    if (p < 40) begin
      k = $urandom_range(9);
      wt = (k < 4) ? gbfs_pkg::T_EMPTY : (k < 7) ? gbfs_pkg::T_WALL :
           (k == 7) ? gbfs_pkg::T_END : 3'($urandom_range(7, 3));
      r = walled ? 6'($urandom) : 6'($urandom_range(7));
      c = walled ? 6'($urandom) : 6'($urandom_range(7));
      if (walled && ((r == blk_r0 && c == blk_c0) || (r == blk_r1 && c == blk_c1)))
        wt = gbfs_pkg::T_WALL;
      send(gbfs_pkg::CMD_WRITE, r, c, wt);
    end else if (p < 65) begin
      k = written_list[$urandom_range(written_list.size() - 1)];
      send(gbfs_pkg::CMD_READ, 6'(k / NCOLS), 6'(k % NCOLS), 3'($urandom));
    end else if (p < 90) begin
      send(gbfs_pkg::CMD_SEARCH, 6'($urandom), 6'($urandom), 3'($urandom));
    end else begin
      send(gbfs_pkg::CMD_UNDEF, 6'($urandom), 6'($urandom), 3'($urandom));
    end
  endtask

  task automatic run_phase(bit [6:0] nr, bit [6:0] nc, bit [6:0] sr, bit [6:0] sc,
                           bit walled, int n);
    reg_write(gbfs_pkg::REG_ROWS, nr);
    reg_write(gbfs_pkg::REG_COLS, nc);
    reg_write(gbfs_pkg::REG_SROW, sr);
    reg_write(gbfs_pkg::REG_SCOL, sc);
    if (walled) begin
      blk_r0 = (sr == 0) ? 6'd1 : 6'(sr - 1);
      blk_c0 = 6'(sc);
      blk_r1 = 6'(sr);
      blk_c1 = (sc == 0) ? 6'd1 : 6'(sc - 1);
      send(gbfs_pkg::CMD_WRITE, blk_r0, blk_c0, gbfs_pkg::T_WALL);
      send(gbfs_pkg::CMD_WRITE, blk_r1, blk_c1, gbfs_pkg::T_WALL);
    end
    send(gbfs_pkg::CMD_SEARCH, '0, '0, '0);
    repeat (n) random_item(walled);
    send(gbfs_pkg::CMD_SEARCH, '0, '0, '0);
    send(gbfs_pkg::CMD_READ, 6'(sr), 6'(sc), '0);
    drain();
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = 0;
    cfg_pwdata = 0;
    quiet = 0;
    hold_req = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // fill the 8x8 working region, then directed cases
    quiet = 1;
    reg_write(gbfs_pkg::REG_ROWS, 7'd8);
    reg_write(gbfs_pkg::REG_COLS, 7'd8);
    reg_write(gbfs_pkg::REG_SROW, 7'd0);
    reg_write(gbfs_pkg::REG_SCOL, 7'd0);
    for (int i = 0; i < 64; i++)
      send(gbfs_pkg::CMD_WRITE, 6'(i / 8), 6'(i % 8), gbfs_pkg::T_EMPTY);
    send(gbfs_pkg::CMD_WRITE, 6'd7, 6'd7, gbfs_pkg::T_END);
    send(gbfs_pkg::CMD_WRITE, 6'd3, 6'd3, gbfs_pkg::T_WALL);
    send(gbfs_pkg::CMD_SEARCH, '0, '0, '0);
    send(gbfs_pkg::CMD_READ, 6'd7, 6'd7, '0);
    send(gbfs_pkg::CMD_READ, 6'd6, 6'd7, '0);
    send(gbfs_pkg::CMD_READ, 6'd1, 6'd0, '0);
    send(gbfs_pkg::CMD_READ, 6'd3, 6'd3, '0);
    send(gbfs_pkg::CMD_WRITE, 6'd63, 6'd63, 3'd7);
    send(gbfs_pkg::CMD_READ, 6'd63, 6'd63, '0);
    send(gbfs_pkg::CMD_WRITE, 6'd2, 6'd2, 3'd5);
    send(gbfs_pkg::CMD_WRITE, 6'd2, 6'd4, 3'd6);
    send(gbfs_pkg::CMD_WRITE, 6'd0, 6'd0, gbfs_pkg::T_WALL);
    send(gbfs_pkg::CMD_READ, 6'd2, 6'd2, '0);
    send(gbfs_pkg::CMD_UNDEF, 6'd63, 6'd63, 3'd7);
    send(gbfs_pkg::CMD_WRITE, 6'd5, 6'd5, gbfs_pkg::T_END);
    send(gbfs_pkg::CMD_SEARCH, '0, '0, '0);
    send(gbfs_pkg::CMD_READ, 6'd0, 6'd0, '0);
    drain();
    quiet = 0;

    hold_req = 1;
    run_phase(7'd8, 7'd8, 7'd3, 7'd5, 0, 3);
    run_phase(7'd0, 7'd0, 7'd0, 7'd0, 0, 1);
    run_phase(7'd5, 7'd8, 7'd7, 7'd2, 0, 1);
    run_phase(7'd6, 7'd3, 7'd5, 7'd2, 0, 2);
    run_phase(7'd64, 7'd64, 7'd0, 7'd0, 1, 1);
    run_phase(7'd127, 7'd127, 7'd63, 7'd63, 1, 1);
    run_phase(7'd8, 7'd8, 7'd7, 7'd7, 0, 2);

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
